// ===== rtl/sls_pkg.sv =====
// Shared types, register indexes and round tables for the Salsa20/HSalsa20 core.
`default_nettype none

package sls_pkg;

   typedef logic [31:0] word_type;
   typedef logic [15:0][31:0] block_type;

   // One word in flight: working state plus the initial state for feed-forward
   typedef struct packed {
      block_type state;
      block_type init;
   } lane_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_HSALSA = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONST_WORD0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONST_WORD1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONST_WORD2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONST_WORD3 = 3'd4;

   // Reset values of the constant words ("expand 32-byte k")
   localparam word_type CONST_WORD0_RESET = 32'h6170_7865;
   localparam word_type CONST_WORD1_RESET = 32'h3320_646e;
   localparam word_type CONST_WORD2_RESET = 32'h7962_2d32;
   localparam word_type CONST_WORD3_RESET = 32'h6b20_6574;

   // Quarter-round word positions (a, b, c, d) for column and row rounds
   localparam logic [0:3][0:3][3:0] COLUMN_IDX = '{
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}
   };
   localparam logic [0:3][0:3][3:0] ROW_IDX = '{
      '{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd5,  4'd6,  4'd7,  4'd4},
      '{4'd10, 4'd11, 4'd8,  4'd9},
      '{4'd15, 4'd12, 4'd13, 4'd14}
   };

   function automatic logic [3:0] quarter_pos(input logic row, input logic [1:0] q,
                                               input logic [1:0] pos);
      return row ? ROW_IDX[q][pos] : COLUMN_IDX[q][pos];
   endfunction

   // Rotation for each of the four add-rotate-xor steps
   function automatic int rot_amount(input logic [1:0] step);
      int n;
      unique case (step)
         2'd0:    n = 7;
         2'd1:    n = 9;
         2'd2:    n = 13;
         default: n = 18;
      endcase
      return n;
   endfunction

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/salsa20_hsalsa20_core.sv =====
// Salsa20/HSalsa20 core: chain of 4*ROUND_COUNT add-rotate-xor cells plus output register.
// Each accepted word passes through every cell register and then the output register.
// Throughput: one word per cycle, set by the cell chain, unless a result is stalled; every cell advances together.
// A stalled result holds the whole chain; req_ready follows the output register.
// Reset (synchronous) clears all valid flags and loads mode_hsalsa = 1 and the
// standard "expand 32-byte k" constant words.
`default_nettype none

module salsa20_hsalsa20_core #(
   parameter int ROUND_COUNT = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [63:0]                         req_in_lo,
   input  logic [63:0]                         req_in_hi,
   input  logic [63:0]                         req_key_0,
   input  logic [63:0]                         req_key_1,
   input  logic [63:0]                         req_key_2,
   input  logic [63:0]                         req_key_3,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [63:0]                         rsp_out_0,
   output logic [63:0]                         rsp_out_1,
   output logic [63:0]                         rsp_out_2,
   output logic [63:0]                         rsp_out_3,
   output logic [63:0]                         rsp_out_4,
   output logic [63:0]                         rsp_out_5,
   output logic [63:0]                         rsp_out_6,
   output logic [63:0]                         rsp_out_7,
   // configuration writes
   input  logic                                csr_write_en,
   input  logic [sls_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);
   import sls_pkg::*;

   localparam int NUM_CELLS = 4 * ROUND_COUNT;

   logic      mode_hsalsa_ff;
   word_type  const_word0_ff, const_word1_ff, const_word2_ff, const_word3_ff;
   logic      advance;
   lane_type  load_lane;
   logic      stage_valid [NUM_CELLS+1];
   lane_type  stage_lane  [NUM_CELLS+1];
   logic [7:0][63:0] result_words;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_hsalsa_ff <= 1'b1;
         const_word0_ff <= CONST_WORD0_RESET;
         const_word1_ff <= CONST_WORD1_RESET;
         const_word2_ff <= CONST_WORD2_RESET;
         const_word3_ff <= CONST_WORD3_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE_HSALSA: mode_hsalsa_ff <= csr_wdata[0];
            CSR_CONST_WORD0: const_word0_ff <= csr_wdata;
            CSR_CONST_WORD1: const_word1_ff <= csr_wdata;
            CSR_CONST_WORD2: const_word2_ff <= csr_wdata;
            CSR_CONST_WORD3: const_word3_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole chain moves unless a finished result is stalled
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Initial state layout
   always_comb begin
      load_lane.state[0]  = const_word0_ff;
      load_lane.state[1]  = req_key_0[31:0];
      load_lane.state[2]  = req_key_0[63:32];
      load_lane.state[3]  = req_key_1[31:0];
      load_lane.state[4]  = req_key_1[63:32];
      load_lane.state[5]  = const_word1_ff;
      load_lane.state[6]  = req_in_lo[31:0];
      load_lane.state[7]  = req_in_lo[63:32];
      load_lane.state[8]  = req_in_hi[31:0];
      load_lane.state[9]  = req_in_hi[63:32];
      load_lane.state[10] = const_word2_ff;
      load_lane.state[11] = req_key_2[31:0];
      load_lane.state[12] = req_key_2[63:32];
      load_lane.state[13] = req_key_3[31:0];
      load_lane.state[14] = req_key_3[63:32];
      load_lane.state[15] = const_word3_ff;
      load_lane.init      = load_lane.state;
   end

   assign stage_valid[0] = req_valid;
   assign stage_lane[0]  = load_lane;

   // Round chain: four cells per round, rounds alternate column/row
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      sls_cell #(
         .STEP (i % 4),
         .ROW  (1'((i / 4) % 2))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (stage_valid[i]),
         .lane_in   (stage_lane[i]),
         .valid_out (stage_valid[i+1]),
         .lane_out  (stage_lane[i+1])
      );
   end

   sls_out u_out (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .valid_in    (stage_valid[NUM_CELLS]),
      .lane_in     (stage_lane[NUM_CELLS]),
      .mode_hsalsa (mode_hsalsa_ff),
      .valid_out   (rsp_valid),
      .words_out   (result_words)
   );

   assign rsp_out_0 = result_words[0];
   assign rsp_out_1 = result_words[1];
   assign rsp_out_2 = result_words[2];
   assign rsp_out_3 = result_words[3];
   assign rsp_out_4 = result_words[4];
   assign rsp_out_5 = result_words[5];
   assign rsp_out_6 = result_words[6];
   assign rsp_out_7 = result_words[7];

   // An accepted word lands in the first cell on the next edge
   a_first_cell_load: assert property (@(posedge clock) disable iff (reset)
      advance |=> stage_valid[1] == $past(req_valid))
      else $error("first cell valid does not follow accepted input");

   // A stall freezes the tail of the chain
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> stage_valid[NUM_CELLS] == $past(stage_valid[NUM_CELLS]))
      else $error("last cell changed during output stall");

   // Results only come out of an occupied last cell
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      advance && !stage_valid[NUM_CELLS] |=> !rsp_valid)
      else $error("result valid without a word in the last cell");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== rtl/sls_cell.sv =====
// One cell of the round chain: a single add-rotate-xor step on all four quarters.
`default_nettype none

module sls_cell #(
   parameter int STEP = 0,
   parameter bit ROW  = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_in,
   input  sls_pkg::lane_type lane_in,
   output logic             valid_out,
   output sls_pkg::lane_type lane_out
);
   import sls_pkg::*;

   // Position within (a, b, c, d): dst ^= rotl(src1 + src2)
   localparam logic [1:0] DST_POS  = 2'((STEP + 1) % 4);
   localparam logic [1:0] SRC1_POS = 2'(STEP % 4);
   localparam logic [1:0] SRC2_POS = 2'((STEP + 3) % 4);
   localparam int         ROT      = rot_amount(2'(STEP % 4));

   logic     valid_ff;
   lane_type lane_ff, lane_step_in;

   // Four independent quarter updates
   always_comb begin
      word_type sum;
      lane_step_in = lane_in;
      for (int q = 0; q < 4; q++) begin
         sum = lane_in.state[quarter_pos(ROW, 2'(q), SRC1_POS)]
             + lane_in.state[quarter_pos(ROW, 2'(q), SRC2_POS)];
         lane_step_in.state[quarter_pos(ROW, 2'(q), DST_POS)] =
            lane_in.state[quarter_pos(ROW, 2'(q), DST_POS)] ^ rotl(sum, ROT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_step_in;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;

endmodule

`default_nettype wire

// ===== rtl/sls_out.sv =====
// Output stage: feed-forward or HSalsa20 word selection into the result register.
`default_nettype none

module sls_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_in,
   input  sls_pkg::lane_type      lane_in,
   input  logic                   mode_hsalsa,
   output logic                   valid_out,
   output logic [7:0][63:0]       words_out
);
   import sls_pkg::*;

   logic              valid_ff;
   logic [7:0][63:0]  words_ff, words_in;
   block_type         sum_block;

   // Salsa20 feed-forward, one add per word
   always_comb begin
      for (int w = 0; w < 16; w++) begin
         sum_block[w] = lane_in.state[w] + lane_in.init[w];
      end
   end

   always_comb begin
      if (mode_hsalsa) begin
         words_in[0] = {lane_in.state[5],  lane_in.state[0]};
         words_in[1] = {lane_in.state[15], lane_in.state[10]};
         words_in[2] = {lane_in.state[7],  lane_in.state[6]};
         words_in[3] = {lane_in.state[9],  lane_in.state[8]};
         for (int k = 4; k < 8; k++) begin
            words_in[k] = '0;
         end
      end else begin
         for (int k = 0; k < 8; k++) begin
            words_in[k] = {sum_block[2*k+1], sum_block[2*k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         words_ff <= words_in;
      end
   end

   assign valid_out = valid_ff;
   assign words_out = words_ff;

endmodule

`default_nettype wire

// ===== bench/salsa_block_checker.sv =====
// Checker for the Salsa20/HSalsa20 core: watches all ports, predicts each block, compares results.
module salsa_block_checker #(
   parameter int ROUNDS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [63:0]                       req_in_lo,
   input  logic [63:0]                       req_in_hi,
   input  logic [63:0]                       req_key_0,
   input  logic [63:0]                       req_key_1,
   input  logic [63:0]                       req_key_2,
   input  logic [63:0]                       req_key_3,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [63:0]                       rsp_out_0,
   input  logic [63:0]                       rsp_out_1,
   input  logic [63:0]                       rsp_out_2,
   input  logic [63:0]                       rsp_out_3,
   input  logic [63:0]                       rsp_out_4,
   input  logic [63:0]                       rsp_out_5,
   input  logic [63:0]                       rsp_out_6,
   input  logic [63:0]                       rsp_out_7,
   input  logic                              csr_write_en,
   input  logic [sls_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_wdata,
   output int                                mismatch_count,
   output int                                words_waiting,
   output int                                words_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import sls_pkg::*;

   // Quarter-round word positions, four nibbles (a, b, c, d) per quarter, quarter 0 lowest
   localparam logic [63:0] COLUMN_ORDER = 64'hB73F_62EA_1D95_C840;
   localparam logic [63:0] ROW_ORDER    = 64'hEDCF_98BA_4765_3210;
   localparam int REPORT_CAP = 100;

   typedef logic [7:0][63:0] out_block_type;

   logic             hsalsa_mode;
   logic [3:0][31:0] sigma_words;
   out_block_type    expected_blocks[$];

   function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Full block function at the current register settings
   function automatic out_block_type salsa_expect(input logic [63:0] blk_lo, blk_hi,
                                                  input logic [63:0] k0, k1, k2, k3);
      logic [31:0]   x [16];
      logic [31:0]   x0 [16];
      logic [63:0]   order;
      int            a, b, c, d;
      out_block_type res;
      x[0]  = sigma_words[0];
      x[5]  = sigma_words[1];
      x[10] = sigma_words[2];
      x[15] = sigma_words[3];
      x[1]  = k0[31:0];
      x[2]  = k0[63:32];
      x[3]  = k1[31:0];
      x[4]  = k1[63:32];
      x[6]  = blk_lo[31:0];
      x[7]  = blk_lo[63:32];
      x[8]  = blk_hi[31:0];
      x[9]  = blk_hi[63:32];
      x[11] = k2[31:0];
      x[12] = k2[63:32];
      x[13] = k3[31:0];
      x[14] = k3[63:32];
      x0 = x;
      // even rounds work on columns, odd rounds on rows
      for (int rnd = 0; rnd < ROUNDS; rnd++) begin
         order = (rnd % 2 == 1) ? ROW_ORDER : COLUMN_ORDER;
         for (int q = 0; q < 4; q++) begin
            a = int'(order[16*q +: 4]);
            b = int'(order[16*q + 4 +: 4]);
            c = int'(order[16*q + 8 +: 4]);
            d = int'(order[16*q + 12 +: 4]);
            x[b] = x[b] ^ rol32(x[a] + x[d], 7);
            x[c] = x[c] ^ rol32(x[b] + x[a], 9);
            x[d] = x[d] ^ rol32(x[c] + x[b], 13);
            x[a] = x[a] ^ rol32(x[d] + x[c], 18);
         end
      end
      if (hsalsa_mode) begin
         // diagonal and input-position words, no feed-forward, upper half zero
         res[0] = {x[5], x[0]};
         res[1] = {x[15], x[10]};
         res[2] = {x[7], x[6]};
         res[3] = {x[9], x[8]};
         for (int k = 4; k < 8; k++) res[k] = '0;
      end else begin
         for (int k = 0; k < 8; k++)
            res[k] = {x[2*k+1] + x0[2*k+1], x[2*k] + x0[2*k]};
      end
      return res;
   endfunction

   // Sample the ports once per edge: predict, compare, track register writes
   always @(posedge clock) begin : watch
      out_block_type seen;
      out_block_type want;
      int            fresh;
      fresh = 0;
      if (reset) begin
         hsalsa_mode <= 1'b1;
         sigma_words <= {32'h6b20_6574, 32'h7962_2d32, 32'h3320_646e, 32'h6170_7865};
         expected_blocks.delete();
         mismatch_count <= 0;
         words_waiting <= 0;
         words_checked <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_blocks.push_back(salsa_expect(req_in_lo, req_in_hi, req_key_0,
                                                   req_key_1, req_key_2, req_key_3));
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_out_7, rsp_out_6, rsp_out_5, rsp_out_4,
                    rsp_out_3, rsp_out_2, rsp_out_1, rsp_out_0};
            if (expected_blocks.size() == 0) begin
               fresh++;
               if (mismatch_count < REPORT_CAP)
                  $display("%0t: result word with nothing expected: expected none, got %h",
                           $time, seen);
            end else begin
               want = expected_blocks.pop_front();
               for (int k = 0; k < 8; k++) begin
                  if (seen[k] !== want[k]) begin
                     if (mismatch_count + fresh < REPORT_CAP)
                        $display("%0t: out_%0d mismatch: expected %h, got %h",
                                 $time, k, want[k], seen[k]);
                     fresh++;
                  end
               end
            end
            words_checked <= words_checked + 1;
         end
         // out-of-range indexes are dropped; only the low bit of the mode write counts
         if (csr_write_en) begin
            case (csr_index)
               CSR_MODE_HSALSA: hsalsa_mode <= csr_wdata[0];
               CSR_CONST_WORD0: sigma_words[0] <= csr_wdata;
               CSR_CONST_WORD1: sigma_words[1] <= csr_wdata;
               CSR_CONST_WORD2: sigma_words[2] <= csr_wdata;
               CSR_CONST_WORD3: sigma_words[3] <= csr_wdata;
               default: ;
            endcase
         end
         mismatch_count <= mismatch_count + fresh;
         words_waiting <= expected_blocks.size();
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the Salsa20/HSalsa20 core bench: clock, reset, stimulus, idling and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sls_pkg::*;

   localparam int ROUNDS      = 20;
   localparam int LATENCY     = 4 * ROUNDS + 1;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_WORDS = 165;
   localparam int PHASES      = 8;

   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA3 = 32'h6b20_6574;
   localparam logic [63:0] ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALT_A  = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [63:0] ALT_5  = 64'h5555_5555_5555_5555;
   localparam logic [63:0] TOPBIT = 64'h8000_0000_0000_0000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [63:0]               req_in_lo;
   logic [63:0]               req_in_hi;
   logic [63:0]               req_key_0;
   logic [63:0]               req_key_1;
   logic [63:0]               req_key_2;
   logic [63:0]               req_key_3;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [63:0]               rsp_out_0;
   logic [63:0]               rsp_out_1;
   logic [63:0]               rsp_out_2;
   logic [63:0]               rsp_out_3;
   logic [63:0]               rsp_out_4;
   logic [63:0]               rsp_out_5;
   logic [63:0]               rsp_out_6;
   logic [63:0]               rsp_out_7;
   logic                      csr_write_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [31:0]               csr_wdata;
   int                        mismatch_count;
   int                        words_waiting;
   int                        words_checked;

   logic calm;          // no idling on either side while set
   int   rsp_hold;
   int   quiet_cycles;
   int   words_sent;
   int   settings_used;

   salsa20_hsalsa20_core #(.ROUND_COUNT(ROUNDS)) uut (.*);

   salsa_block_checker #(.ROUNDS(ROUNDS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stall bursts of random length unless calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold <= 0;
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_hold <= $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || csr_write_en || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one word and hold it until taken, then maybe idle for a burst
   task automatic push_word(input logic [63:0] lo, hi, k0, k1, k2, k3);
      req_valid <= 1'b1;
      req_in_lo <= lo;
      req_in_hi <= hi;
      req_key_0 <= k0;
      req_key_1 <= k1;
      req_key_2 <= k2;
      req_key_3 <= k3;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Mostly random bits, with zeros, all-ones and single bits mixed in
   function automatic logic [63:0] pick_field();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ONES;
         2: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic push_random();
      push_word(pick_field(), pick_field(), pick_field(),
                pick_field(), pick_field(), pick_field());
   endtask

   // Field extremes and patterns; each field alone at all-ones
   task automatic push_directed();
      push_word('0, '0, '0, '0, '0, '0);
      push_word(ONES, ONES, ONES, ONES, ONES, ONES);
      push_word(ONES, '0, '0, '0, '0, '0);
      push_word('0, ONES, '0, '0, '0, '0);
      push_word('0, '0, ONES, '0, '0, '0);
      push_word('0, '0, '0, ONES, '0, '0);
      push_word('0, '0, '0, '0, ONES, '0);
      push_word('0, '0, '0, '0, '0, ONES);
      push_word(ALT_A, ALT_5, ALT_A, ALT_5, ALT_A, ALT_5);
      push_word(64'd1, TOPBIT, 64'd1, TOPBIT, 64'd1, TOPBIT);
   endtask

   // Drop valid and wait until every expected result is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write every register, then the unused indexes, which must be ignored
   task automatic load_regs(input logic mode, input logic [31:0] c0, c1, c2, c3);
      csr_put(CSR_MODE_HSALSA, ($urandom() & 32'hFFFF_FFFE) | {31'd0, mode});
      csr_put(CSR_CONST_WORD0, c0);
      csr_put(CSR_CONST_WORD1, c1);
      csr_put(CSR_CONST_WORD2, c2);
      csr_put(CSR_CONST_WORD3, c3);
      for (int k = int'(CSR_CONST_WORD3) + 1; k < (1 << CSR_INDEX_W); k++)
         csr_put(CSR_INDEX_W'(k), $urandom());
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_lo <= '0;
      req_in_hi <= '0;
      req_key_0 <= '0;
      req_key_1 <= '0;
      req_key_2 <= '0;
      req_key_3 <= '0;
      csr_write_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      calm <= 1'b0;
      words_sent = 0;
      settings_used = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset settings (HSalsa20), then in Salsa20 mode
      push_directed();
      settle();
      load_regs(1'b0, SIGMA0, SIGMA1, SIGMA2, SIGMA3);
      push_directed();
      settle();

      // random phases across constant extremes and both modes; last phase never idles
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_regs(1'b1, '0, '0, '0, '0);
            1: load_regs(1'b0, '1, '1, '1, '1);
            2: load_regs(1'b1, '1, '1, '1, '1);
            3: load_regs(1'b0, '0, '0, '0, '0);
            4: load_regs(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
            5: load_regs(1'b0, $urandom(), $urandom(), $urandom(), $urandom());
            6: load_regs(1'b0, SIGMA0, SIGMA1, SIGMA2, SIGMA3);
            default: load_regs(1'b1, SIGMA0, SIGMA1, SIGMA2, SIGMA3);
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0)
               calm <= (phase == PHASES - 1) || ($urandom_range(0, 3) == 0);
            push_random();
         end
         settle();
      end

      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d blocks over %0d register settings, both output modes,",
               words_sent, settings_used);
      $display("zero, all-ones, standard and random constants; %0d results checked.",
               words_checked);
      if (words_waiting != 0)
         $display("%0t: %0d expected results never arrived", $time, words_waiting);
      if (mismatch_count == 0 && words_waiting == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
